// ===== rtl/lru_key_cache_with_dirty_tracking_defines.svh =====
// Assertion macros used by the checker lkc_checker.
`ifndef LRU_KEY_CACHE_WITH_DIRTY_TRACKING_DEFINES_SVH
`define LRU_KEY_CACHE_WITH_DIRTY_TRACKING_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LKC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkc: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define LKC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkc: next-cycle check failed");

`endif

// ===== rtl/lkc_pkg.sv =====
package lkc_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned IN_DATA_W    = 96;
  localparam int unsigned IN_USER_W    = 2;
  localparam int unsigned OUT_DATA_W   = 104;
  localparam int unsigned OUT_USER_W   = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } lkc_state_e;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } lkc_cmd_t;

endpackage

// ===== rtl/lkc_ctrl.sv =====
module lkc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output lkc_pkg::lkc_cmd_t cmd_o
);

  lkc_pkg::lkc_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lkc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      lkc_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lkc_pkg::S_CMP;
        end
      end
      lkc_pkg::S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = lkc_pkg::S_UPD;
      end
      lkc_pkg::S_UPD: begin
        // wait for the output register to free up
        if (!out_valid_q || m_tready_i) begin
          cmd_o.update = 1'b1;
          state_d      = lkc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lkc_pkg::S_IDLE;
      end
    endcase

    if (cmd_o.update) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

// ===== rtl/lkc_dp.sv =====
module lkc_dp #(
  parameter int unsigned CAPACITY = lkc_pkg::DEF_CAPACITY
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkc_pkg::lkc_cmd_t                 cmd_i,
  input  logic [lkc_pkg::IN_DATA_W-1:0]     s_tdata_i,
  input  logic [lkc_pkg::IN_USER_W-1:0]     s_tuser_i,
  output logic [lkc_pkg::OUT_DATA_W-1:0]    m_tdata_o,
  output logic [lkc_pkg::OUT_USER_W-1:0]    m_tuser_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned FC_W  = $clog2(CAPACITY + 1);
  localparam int unsigned KW    = lkc_pkg::KEY_W;
  localparam int unsigned SW    = lkc_pkg::SLOT_W;

  logic [KW-1:0]       key_x_q, key_y_q, key_z_q;
  logic                edit_q, fresh_q;

  logic [KW-1:0]       tag_x_q [CAPACITY];
  logic [KW-1:0]       tag_y_q [CAPACITY];
  logic [KW-1:0]       tag_z_q [CAPACITY];
  logic [CAPACITY-1:0] dirty_q;
  logic [IDX_W-1:0]    rank_q  [CAPACITY];
  logic [FC_W-1:0]     free_q;

  logic [CAPACITY-1:0] match_q, match_d;
  logic [CAPACITY-1:0] lru_q, lru_d;

  logic                out_hit_q, out_ev_valid_q, out_ev_dirty_q;
  logic [SW-1:0]       out_slot_q;
  logic [KW-1:0]       out_ev_x_q, out_ev_y_q, out_ev_z_q;

  logic                hit, full, evict;
  logic [IDX_W-1:0]    hit_idx, lru_idx, hit_rank, target;
  logic [FC_W-1:0]     free_m1;
  logic [KW-1:0]       sel_x, sel_y, sel_z;
  logic                sel_dirty;
  logic [IDX_W+SW-1:0] slot_ext;

  // parallel tag compare and LRU pick
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = (FC_W'(i) >= free_q) && (tag_x_q[i] == key_x_q) &&
                   (tag_y_q[i] == key_y_q) && (tag_z_q[i] == key_z_q);
      lru_d[i]   = (rank_q[i] == IDX_W'(CAPACITY - 1));
    end
  end

  // one-hot selects
  always_comb begin
    hit_idx   = '0;
    hit_rank  = '0;
    lru_idx   = '0;
    sel_x     = '0;
    sel_y     = '0;
    sel_z     = '0;
    sel_dirty = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_q[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank_q[i];
      end
      if (lru_q[i]) begin
        lru_idx   = lru_idx | IDX_W'(i);
        sel_x     = sel_x | tag_x_q[i];
        sel_y     = sel_y | tag_y_q[i];
        sel_z     = sel_z | tag_z_q[i];
        sel_dirty = sel_dirty | dirty_q[i];
      end
    end
  end

  assign hit      = |match_q;
  assign full     = (free_q == '0);
  assign evict    = !hit && full;
  assign free_m1  = free_q - FC_W'(1);
  assign target   = hit ? hit_idx : (full ? lru_idx : free_m1[IDX_W-1:0]);
  assign slot_ext = {{SW{1'b0}}, target};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_x_q <= s_tdata_i[KW-1:0];
      key_y_q <= s_tdata_i[2*KW-1:KW];
      key_z_q <= s_tdata_i[3*KW-1:2*KW];
      edit_q  <= s_tuser_i[0];
      fresh_q <= s_tuser_i[1];
    end
    if (cmd_i.compare) begin
      match_q <= match_d;
      lru_q   <= lru_d;
    end
    if (cmd_i.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (!hit && (IDX_W'(i) == target)) begin
          tag_x_q[i] <= key_x_q;
          tag_y_q[i] <= key_y_q;
          tag_z_q[i] <= key_z_q;
        end
      end
      out_hit_q      <= hit;
      out_slot_q     <= slot_ext[SW-1:0];
      out_ev_valid_q <= evict;
      out_ev_dirty_q <= evict & sel_dirty;
      out_ev_x_q     <= evict ? sel_x : '0;
      out_ev_y_q     <= evict ? sel_y : '0;
      out_ev_z_q     <= evict ? sel_z : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= '0;
      free_q  <= FC_W'(CAPACITY);
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (IDX_W'(i) == target) begin
          rank_q[i]  <= '0;
          dirty_q[i] <= hit ? (dirty_q[i] | edit_q) : (fresh_q | edit_q);
        end else if (!hit || (rank_q[i] < hit_rank)) begin
          rank_q[i] <= rank_q[i] + IDX_W'(1);
        end
      end
      if (!hit && !full) begin
        free_q <= free_m1;
      end
    end
  end

  assign m_tdata_o = {{(lkc_pkg::OUT_DATA_W - SW - 3 * KW){1'b0}},
                      out_ev_z_q, out_ev_y_q, out_ev_x_q, out_slot_q};
  assign m_tuser_o = {out_ev_dirty_q, out_ev_valid_q, out_hit_q};

endmodule

// ===== rtl/lru_key_cache_with_dirty_tracking.sv =====
// Fully associative LRU key cache with dirty tracking. Each request carries a
// 96-bit key (x, y, z) plus edit and fill_is_new flags, and returns one result:
// hit, the slot now holding the key, and on an eviction the evicted key and its
// dirty bit (zero when nothing is evicted). Misses fill free slots from the
// highest number down, then replace the least recent entry. A request runs
// through capture, a parallel compare of the key against every tag, and an
// update of all recency ranks at once; a new request is accepted only once
// the last one has finished its update, and the update step waits while the
// previous result has not been taken. Tags are not cleared at reset and no
// clearing pass runs; the block is ready right after reset.
module lru_key_cache_with_dirty_tracking #(
  parameter int unsigned CAPACITY = lkc_pkg::DEF_CAPACITY
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key_x[31:0], key_y[63:32], key_z[95:64]
  input  logic [lkc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // edit[0], fill_is_new[1]
  input  logic [lkc_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // slot[5:0], evict_x[37:6], evict_y[69:38], evict_z[101:70], zero[103:102]
  output logic [lkc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // hit[0], evict_valid[1], evict_dirty[2]
  output logic [lkc_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  lkc_pkg::lkc_cmd_t cmd;

  lkc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  lkc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser)
  );

endmodule

// ===== rtl/lkc_checker.sv =====
`include "lru_key_cache_with_dirty_tracking_defines.svh"

module lkc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lkc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [lkc_pkg::OUT_USER_W-1:0] m_axis_tuser
);

  // an eviction only happens on a miss
`LKC_ASSERT_SAME(a_evict_on_miss, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0])

  // no eviction: evicted key and dirty bit read as zero
`LKC_ASSERT_SAME(a_no_evict_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[1], !m_axis_tuser[2] && (m_axis_tdata[101:6] == '0))

  // one request in flight: no transfer right after an input transfer
`LKC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // stalled result holds
`LKC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind lru_key_cache_with_dirty_tracking lkc_checker u_lkc_checker (.*);
